>>> rtl/hkvt_pkg.sv
// Shared types and codes for the hashed key/value table.
`timescale 1ns / 1ps

package hkvt_pkg;

  // Fixed widths of the request and response fields
  localparam int FUNC_W      = 2;
  localparam int KEY_IN_W    = 32;
  localparam int VALUE_IN_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int DATA_OUT_W  = 32;
  localparam int COUNT_OUT_W = 9;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // One request item
  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [KEY_IN_W-1:0]   key;
    logic [VALUE_IN_W-1:0] value;
  } req_t;

  // One response item
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [DATA_OUT_W-1:0]  read_data;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // Outcome of the way compare for one request
  typedef struct packed {
    logic                  wr_en;
    logic                  inc;
    logic                  dec;
    logic [STATUS_W-1:0]   status;
    logic [DATA_OUT_W-1:0] read_data;
  } verdict_t;

endpackage

>>> rtl/hkvt_req_if.sv
// Request channel: operation, key and value with valid/ready.
`timescale 1ns / 1ps

interface hkvt_req_if;
  logic                             valid;
  logic                             ready;
  logic [hkvt_pkg::FUNC_W-1:0]      func;
  logic [hkvt_pkg::KEY_IN_W-1:0]    key;
  logic [hkvt_pkg::VALUE_IN_W-1:0]  value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

>>> rtl/hkvt_rsp_if.sv
// Response channel: status, read data and entry count with valid/ready.
`timescale 1ns / 1ps

interface hkvt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [hkvt_pkg::STATUS_W-1:0]     status;
  logic [hkvt_pkg::DATA_OUT_W-1:0]   read_data;
  logic [hkvt_pkg::COUNT_OUT_W-1:0]  entry_count;

  modport source (output valid, output status, output read_data, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input entry_count,
                  output ready);
endinterface

>>> rtl/hkvt_bucket_hash.sv
// Key modulo BUCKETS by reciprocal multiply: input and product registers.
`timescale 1ns / 1ps

module hkvt_bucket_hash #(
  parameter int BUCKETS = 64,
  parameter int KW      = 32,
  parameter int VW      = 32,
  localparam int BKT_W  = $clog2(BUCKETS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  hkvt_pkg::req_t       in_req,
  output logic                 out_valid,
  output hkvt_pkg::req_t       out_req,
  output logic [BKT_W-1:0]     bucket
);

  localparam int KIN = hkvt_pkg::KEY_IN_W;
  localparam int VIN = hkvt_pkg::VALUE_IN_W;
  localparam logic [KIN-1:0] KEY_MASK =
    (KW >= KIN) ? {KIN{1'b1}} : ((KIN'(1) << KW) - KIN'(1));
  localparam logic [VIN-1:0] VALUE_MASK =
    (VW >= VIN) ? {VIN{1'b1}} : ((VIN'(1) << VW) - VIN'(1));
  // ceil(2^(32+BKT_W) / BUCKETS): exact quotient for every 32-bit key
  localparam int SHIFT = KIN + BKT_W;
  localparam logic [63:0] NUM = 64'd1 << SHIFT;
  localparam logic [KIN:0] RECIP = (KIN + 1)'((NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [BKT_W-1:0] B_LO = BKT_W'(BUCKETS);
  localparam int PROD_W = 2 * KIN + 1;

  hkvt_pkg::req_t     s1_req;
  hkvt_pkg::req_t     s2_req;
  hkvt_pkg::req_t     masked;
  logic               s1_valid;
  logic               s2_valid;
  logic [PROD_W-1:0]  s2_prod;
  logic [KIN-1:0]     quot;

  // Fold the key and value down to their stored widths
  always_comb begin
    masked       = in_req;
    masked.key   = in_req.key & KEY_MASK;
    masked.value = in_req.value & VALUE_MASK;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // Input register, then the reciprocal product
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req  <= masked;
      s2_req  <= s1_req;
      s2_prod <= s1_req.key * RECIP;
    end
  end

  // Remainder: only the low bucket bits of key - q*BUCKETS matter
  always_comb begin
    quot   = KIN'(s2_prod >> SHIFT);
    bucket = s2_req.key[BKT_W-1:0] - BKT_W'(quot[BKT_W-1:0] * B_LO);
  end

  assign out_valid = s2_valid;
  assign out_req   = s2_req;

endmodule

>>> rtl/hkvt_row_store.sv
// Bucket row memory for keys and values, per-way valid flags, write forwarding.
`timescale 1ns / 1ps

module hkvt_row_store #(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4,
  parameter int ROW_W   = 256,
  localparam int BKT_W  = $clog2(BUCKETS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [BKT_W-1:0]   raddr,
  input  logic [BKT_W-1:0]   addr,
  input  logic               we,
  input  logic [ROW_W-1:0]   wrow,
  input  logic [WAYS-1:0]    wvalid,
  output logic [ROW_W-1:0]   row,
  output logic [WAYS-1:0]    vrow
);

  logic [ROW_W-1:0] mem [BUCKETS];
  logic [WAYS-1:0]  vbits [BUCKETS];
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] fwd_row;
  logic [WAYS-1:0]  vrd;
  logic [WAYS-1:0]  fwd_vrow;
  logic             fwd_hit;

  // Key/value rows and flags: one write and one registered read per cycle on adv
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wrow;
    end
    if (adv) begin
      rdata    <= mem[raddr];
      fwd_row  <= wrow;
      vrd      <= vbits[raddr];
      fwd_vrow <= wvalid;
    end
  end

  // A read that collides with this cycle's write sees the new row
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= we && (addr == raddr);
    end
  end

  // Valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) begin
        vbits[b] <= '0;
      end
    end else if (we) begin
      vbits[addr] <= wvalid;
    end
  end

  assign row  = fwd_hit ? fwd_row : rdata;
  assign vrow = fwd_hit ? fwd_vrow : vrd;

endmodule

>>> rtl/hkvt_way_select.sv
// Compares all ways of a bucket and decides the row update and response.
`timescale 1ns / 1ps

module hkvt_way_select #(
  parameter int WAYS = 4,
  parameter int KW   = 32,
  parameter int VW   = 32
) (
  input  hkvt_pkg::req_t                req,
  input  logic [WAYS-1:0][KW-1:0]       keys,
  input  logic [WAYS-1:0][VW-1:0]       vals,
  input  logic [WAYS-1:0]               vrow,
  output logic [WAYS-1:0][KW-1:0]       new_keys,
  output logic [WAYS-1:0][VW-1:0]       new_vals,
  output logic [WAYS-1:0]               new_vrow,
  output hkvt_pkg::verdict_t            verdict
);

  localparam int WIX = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0] match;
  logic [WIX-1:0]  hit_idx;
  logic [WIX-1:0]  free_idx;
  logic            hit;
  logic            has_free;
  logic            bad;

  // Per-way compare; scanning high to low leaves the lowest index
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = vrow[w] && (keys[w] == req.key[KW-1:0]);
      if (match[w]) begin
        hit_idx = WIX'(w);
      end
      if (!vrow[w]) begin
        free_idx = WIX'(w);
      end
    end
    hit      = |match;
    has_free = ~&vrow;
  end

  // Decision
  always_comb begin
    bad = ((req.func != hkvt_pkg::FUNC_INSERT) && (req.func != hkvt_pkg::FUNC_REMOVE)
           && (req.func != hkvt_pkg::FUNC_GET))
          || (req.key == '0)
          || ((req.func == hkvt_pkg::FUNC_INSERT) && (req.value == '0));
    new_keys          = keys;
    new_vals          = vals;
    new_vrow          = vrow;
    verdict.wr_en     = 1'b0;
    verdict.inc       = 1'b0;
    verdict.dec       = 1'b0;
    verdict.status    = hkvt_pkg::ST_OK;
    verdict.read_data = '0;
    if (bad) begin
      verdict.status = hkvt_pkg::ST_BAD_ARG;
    end else if (req.func == hkvt_pkg::FUNC_INSERT) begin
      if (hit) begin
        new_vals[hit_idx] = req.value[VW-1:0];
        verdict.wr_en     = 1'b1;
      end else if (!has_free) begin
        verdict.status = hkvt_pkg::ST_FULL;
      end else begin
        new_keys[free_idx] = req.key[KW-1:0];
        new_vals[free_idx] = req.value[VW-1:0];
        new_vrow[free_idx] = 1'b1;
        verdict.wr_en      = 1'b1;
        verdict.inc        = 1'b1;
      end
    end else if (!hit) begin
      verdict.status = hkvt_pkg::ST_NOT_FOUND;
    end else if (req.func == hkvt_pkg::FUNC_REMOVE) begin
      new_vrow[hit_idx] = 1'b0;
      verdict.wr_en     = 1'b1;
      verdict.dec       = 1'b1;
    end else begin
      verdict.read_data = hkvt_pkg::DATA_OUT_W'(vals[hit_idx]);
    end
  end

endmodule

>>> rtl/hashed_key_value_table_core.sv
// Each request passes the input, product, lookup and output registers.
// Throughput: one item per cycle unless a held response stalls the pipe;
// the bucket row memory takes one row read and one row write each cycle,
// with the just-written row forwarded to the next lookup of that bucket.
// Reset clears all way valid flags and the key count at once; no sweep.
`timescale 1ns / 1ps

module hashed_key_value_table_core #(
  parameter int BUCKETS    = 64,
  parameter int WAYS       = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  hkvt_req_if.sink           req,
  hkvt_rsp_if.source         rsp
);

  localparam int KW     = (KEY_BITS < hkvt_pkg::KEY_IN_W) ? KEY_BITS : hkvt_pkg::KEY_IN_W;
  localparam int VW     = (VALUE_BITS < hkvt_pkg::VALUE_IN_W) ? VALUE_BITS
                                                                : hkvt_pkg::VALUE_IN_W;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int ROW_W  = WAYS * (KW + VW);
  localparam int SLOTS  = BUCKETS * WAYS;
  localparam int CNT_W0 = $clog2(SLOTS + 1);
  localparam int CNT_W  = (CNT_W0 > hkvt_pkg::COUNT_OUT_W) ? CNT_W0 : hkvt_pkg::COUNT_OUT_W;

  logic                     adv;
  logic                     commit;
  logic                     we;
  hkvt_pkg::req_t           in_req;
  logic                     h_valid;
  hkvt_pkg::req_t           h_req;
  logic [BKT_W-1:0]         h_bucket;
  logic                     s3_valid;
  hkvt_pkg::req_t           s3_req;
  logic [BKT_W-1:0]         s3_bucket;
  logic [ROW_W-1:0]         rd_row;
  logic [WAYS-1:0]          vrow;
  logic [WAYS-1:0][KW-1:0]  row_keys;
  logic [WAYS-1:0][VW-1:0]  row_vals;
  logic [WAYS-1:0][KW-1:0]  new_keys;
  logic [WAYS-1:0][VW-1:0]  new_vals;
  logic [WAYS-1:0]          new_vrow;
  hkvt_pkg::verdict_t       verdict;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     out_valid;
  hkvt_pkg::rsp_t           out_rsp;

  // Whole pipe moves when the output register is free or being drained;
  // no item is taken while reset is held
  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv && !rst;
  assign commit    = adv && s3_valid;
  assign we        = commit && verdict.wr_en;

  assign in_req.func  = req.func;
  assign in_req.key   = req.key;
  assign in_req.value = req.value;

  hkvt_bucket_hash #(
    .BUCKETS (BUCKETS),
    .KW      (KW),
    .VW      (VW)
  ) u_hash (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req.valid),
    .in_req    (in_req),
    .out_valid (h_valid),
    .out_req   (h_req),
    .bucket    (h_bucket)
  );

  // Lookup stage register, aligned with the row read
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_req    <= h_req;
      s3_bucket <= h_bucket;
    end
  end

  hkvt_row_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .ROW_W   (ROW_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .raddr  (h_bucket),
    .addr   (s3_bucket),
    .we     (we),
    .wrow   ({new_vals, new_keys}),
    .wvalid (new_vrow),
    .row    (rd_row),
    .vrow   (vrow)
  );

  assign row_keys = rd_row[WAYS*KW-1:0];
  assign row_vals = rd_row[ROW_W-1:WAYS*KW];

  hkvt_way_select #(
    .WAYS (WAYS),
    .KW   (KW),
    .VW   (VW)
  ) u_select (
    .req      (s3_req),
    .keys     (row_keys),
    .vals     (row_vals),
    .vrow     (vrow),
    .new_keys (new_keys),
    .new_vals (new_vals),
    .new_vrow (new_vrow),
    .verdict  (verdict)
  );

  // Key count
  always_comb begin
    count_next = count;
    if (verdict.inc) begin
      count_next = count + CNT_W'(1);
    end else if (verdict.dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp.status      <= verdict.status;
      out_rsp.read_data   <= verdict.read_data;
      out_rsp.entry_count <= count_next[hkvt_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_rsp.status;
  assign rsp.read_data   = out_rsp.read_data;
  assign rsp.entry_count = out_rsp.entry_count;

endmodule

>>> tb/tb_hashed_key_value_table_core.sv
// Testbench for the hashed key/value table: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_hashed_key_value_table_core;
  import hkvt_pkg::*;

  localparam int BUCKETS = 64;
  localparam int WAYS = 4;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int RANDOM_ITEMS = 1750;
  localparam int POOL_SIZE = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One row of the directed table
  typedef struct {
    logic [FUNC_W-1:0]     func;
    logic [KEY_IN_W-1:0]   key;
    logic [VALUE_IN_W-1:0] value;
    bit                    typed;
    rsp_t                  want;
  } dir_row_t;

  logic clk;
  logic rst;

  hkvt_req_if req_ch ();
  hkvt_rsp_if rsp_ch ();

  hashed_key_value_table_core #(
    .BUCKETS   (BUCKETS),
    .WAYS      (WAYS),
    .KEY_BITS  (32),
    .VALUE_BITS(32)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the table
  bit                    shadow_valid [SLOTS];
  logic [KEY_IN_W-1:0]   shadow_key   [SLOTS];
  logic [VALUE_IN_W-1:0] shadow_value [SLOTS];
  int unsigned           shadow_count;

  rsp_t        pending_rsps [$];
  dir_row_t    dir_rows [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatches;
  int          results_seen;
  int unsigned cycle_cnt;
  bit          gaps_on;

  always #5 clk = ~clk;

  // Apply one request to the shadow table and return its response
  function automatic rsp_t table_access(input logic [FUNC_W-1:0] f,
                                        input logic [KEY_IN_W-1:0] k,
                                        input logic [VALUE_IN_W-1:0] v);
    rsp_t r;
    int   base;
    int   hit;
    int   free_slot;
    hit = -1;
    free_slot = -1;
    r.status = ST_OK;
    r.read_data = '0;
    if (f == FUNC_UNUSED || k == '0 || (f == FUNC_INSERT && v == '0)) begin
      r.status = ST_BAD_ARG;
    end else begin
      base = int'(k % BUCKETS) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (shadow_valid[base + w]) begin
          if (hit < 0 && shadow_key[base + w] == k) hit = base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
      if (f == FUNC_INSERT) begin
        if (hit >= 0) begin
          shadow_value[hit] = v;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_valid[free_slot] = 1'b1;
          shadow_key[free_slot] = k;
          shadow_value[free_slot] = v;
          shadow_count++;
        end
      end else if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (f == FUNC_REMOVE) begin
        shadow_valid[hit] = 1'b0;
        shadow_count--;
      end else begin
        r.read_data = shadow_value[hit];
      end
    end
    r.entry_count = shadow_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Some key currently held, or a fresh one if the table is empty
  function automatic logic [31:0] held_key();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[(start + i) % SLOTS]) return shadow_key[(start + i) % SLOTS];
    end
    return $urandom;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [31:0] k,
                         input logic [31:0] v, input bit typed, input rsp_t want);
    dir_row_t row;
    row.func = f;
    row.key = k;
    row.value = v;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d data %h count %0d, got status %0d data %h count %0d",
               $realtime, what, want.status, want.read_data, want.entry_count,
               got.status, got.read_data, got.entry_count);
    end
  endtask

  // Offer one item and hold it until accepted
  task automatic offer(input logic [FUNC_W-1:0] f, input logic [31:0] k,
                       input logic [31:0] v);
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.key <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Idle gap after an item: mostly none, sometimes short, rarely long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (gaps_on) begin
      if (r >= 92) n = $urandom_range(8, 40);
      else if (r >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Receiver: varying ready rate, random stalls, one long hold-off
  initial begin : drive_ready
    bit held_once;
    int ready_pct;
    held_once = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      case ((cycle_cnt / 300) % 3)
        0: ready_pct = 100;
        1: ready_pct = 75;
        default: ready_pct = 40;
      endcase
      if (!held_once && results_seen >= 200) begin
        held_once = 1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (ready_pct < 100 && $urandom_range(0, 99) < 2) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
        @(posedge clk);
      end
    end
  end

  // Compare each response with the oldest expectation
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      got.status = rsp_ch.status;
      got.read_data = rsp_ch.read_data;
      got.entry_count = rsp_ch.entry_count;
      if (pending_rsps.size() == 0) begin
        note_mismatch("response with none pending", '0, got);
      end else begin
        want = pending_rsps.pop_front();
        if (got.status !== want.status || got.read_data !== want.read_data ||
            got.entry_count !== want.entry_count) begin
          note_mismatch("response mismatch", want, got);
        end
      end
    end
  end

  // Time limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    rsp_t        r;
    int          pr;
    int          kr;
    int          vr;
    int          phase;
    logic [1:0]  f;
    logic [31:0] k;
    logic [31:0] v;

    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = '0;
    req_ch.key = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    cycle_cnt = 0;
    gaps_on = 1;
    shadow_count = 0;
    for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
    // Pool keys fall into three buckets so those fill up
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 3)
        0: key_pool[i] = {26'($urandom_range(0, 32'h03FF_FFFF)), 6'd3};
        1: key_pool[i] = {26'($urandom_range(0, 32'h03FF_FFFF)), 6'd17};
        default: key_pool[i] = {26'($urandom_range(0, 32'h03FF_FFFF)), 6'd42};
      endcase
    end

    // Directed rows: empty table, bad arguments, extremes, a full bucket
    add_row(FUNC_GET, 32'd5, 32'd0, 1, {ST_NOT_FOUND, 32'd0, 9'd0});
    add_row(FUNC_REMOVE, 32'd5, 32'd9, 1, {ST_NOT_FOUND, 32'd0, 9'd0});
    add_row(FUNC_INSERT, 32'd0, 32'd1, 1, {ST_BAD_ARG, 32'd0, 9'd0});
    add_row(FUNC_INSERT, 32'd7, 32'd0, 1, {ST_BAD_ARG, 32'd0, 9'd0});
    add_row(FUNC_UNUSED, 32'd7, 32'd9, 1, {ST_BAD_ARG, 32'd0, 9'd0});
    add_row(FUNC_GET, 32'd0, 32'd0, 1, {ST_BAD_ARG, 32'd0, 9'd0});
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, {ST_OK, 32'd0, 9'd1});
    add_row(FUNC_GET, 32'hFFFF_FFFF, 32'd0, 1, {ST_OK, 32'hFFFF_FFFF, 9'd1});
    add_row(FUNC_INSERT, 32'd1, 32'd1, 0, '0);
    add_row(FUNC_INSERT, 32'd65, 32'hA5A5_A5A5, 0, '0);
    add_row(FUNC_INSERT, 32'd129, 32'h5A5A_5A5A, 0, '0);
    add_row(FUNC_INSERT, 32'd193, 32'h8000_0000, 0, '0);
    add_row(FUNC_INSERT, 32'd257, 32'd3, 0, '0);
    add_row(FUNC_INSERT, 32'd65, 32'h1234_5678, 0, '0);
    add_row(FUNC_GET, 32'd65, 32'd0, 0, '0);
    add_row(FUNC_REMOVE, 32'd129, 32'hFFFF_FFFF, 0, '0);
    add_row(FUNC_INSERT, 32'd257, 32'd3, 0, '0);
    add_row(FUNC_GET, 32'd257, 32'd0, 0, '0);
    add_row(FUNC_GET, 32'd129, 32'd0, 0, '0);
    add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 32'd0, 0, '0);
    add_row(FUNC_GET, 32'hFFFF_FFFF, 32'd0, 0, '0);
    add_row(FUNC_REMOVE, 32'd0, 32'd4, 0, '0);
    add_row(FUNC_GET, 32'd1, 32'd0, 0, '0);
    add_row(FUNC_INSERT, 32'h8000_0040, 32'h7FFF_FFFF, 0, '0);
    add_row(FUNC_REMOVE, 32'd3, 32'd1, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].func, dir_rows[i].key, dir_rows[i].value);
      r = table_access(dir_rows[i].func, dir_rows[i].key, dir_rows[i].value);
      pending_rsps.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
      sender_gap();
    end

    // Random traffic: colliding pool, then filling, then draining
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n < 600) ? 0 : (n < 1200) ? 1 : 2;
      gaps_on = ((n / 100) % 3) != 0;
      pr = $urandom_range(0, 99);
      kr = $urandom_range(0, 99);
      vr = $urandom_range(0, 99);
      if (pr < 3) begin
        f = FUNC_UNUSED;
      end else begin
        case (phase)
          0: f = (pr < 43) ? FUNC_INSERT : (pr < 68) ? FUNC_REMOVE : FUNC_GET;
          1: f = (pr < 73) ? FUNC_INSERT : (pr < 81) ? FUNC_REMOVE : FUNC_GET;
          default: f = (pr < 18) ? FUNC_INSERT : (pr < 68) ? FUNC_REMOVE : FUNC_GET;
        endcase
      end
      if (kr < 4) begin
        k = '0;
      end else begin
        case (phase)
          0: k = (kr < 34) ? held_key() : (kr < 84) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                     : $urandom;
          1: k = (kr < 29) ? held_key() : (kr < 39) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                     : $urandom;
          default: k = (kr < 64) ? held_key()
                                 : (kr < 84) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
        endcase
      end
      v = (vr < 5) ? 32'd0 : (vr < 8) ? 32'hFFFF_FFFF : $urandom;
      offer(f, k, v);
      pending_rsps.push_back(table_access(f, k, v));
      sender_gap();
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hkvt_pkg.sv
rtl/hkvt_req_if.sv
rtl/hkvt_rsp_if.sv
rtl/hkvt_bucket_hash.sv
rtl/hkvt_row_store.sv
rtl/hkvt_way_select.sv
rtl/hashed_key_value_table_core.sv
tb/tb_hashed_key_value_table_core.sv
